[rtl/core/reply_frame_checker_defines.svh]
// ----------------------------------------------------------------------------
// Reply frame checker assertion macros
// Shared property forms used by the checker's RTL assertions.
// ----------------------------------------------------------------------------
`ifndef REPLY_FRAME_CHECKER_DEFINES_SVH
`define REPLY_FRAME_CHECKER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define RFC_ASSERT_IMPL(label, cond, conseq, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (conseq)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define RFC_ASSERT_NEXT(label, cond, conseq, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (conseq)) \
      else $error(msg);

`endif

[rtl/core/rfc_pkg.sv]
// ----------------------------------------------------------------------------
// Reply frame checker package
// Types, register indexes, status codes and frame constants of the checker.
// ----------------------------------------------------------------------------
`default_nettype none

package rfc_pkg;

   // Configuration register indexes.
   localparam logic [1:0] CSR_LONG_MODE    = 2'd0;
   localparam logic [1:0] CSR_ECHO_LENGTH  = 2'd1;
   localparam logic [1:0] CSR_EXP_CMD_SUM  = 2'd2;

   // Frame constants.
   localparam logic [7:0]  TERM_CHAR  = 8'h3e;
   localparam logic [15:0] PROMPT_LEN = 16'd6;
   localparam logic [15:0] HDR_SHORT  = 16'd3;
   localparam logic [15:0] HDR_LONG   = 16'd5;

   typedef enum logic [2:0] {
      STATUS_OK,
      STATUS_CMD_SUM,
      STATUS_REPLY_SUM,
      STATUS_BAD_TERM,
      STATUS_TOO_SHORT
   } status_type;

   typedef struct packed {
      logic       long_mode;
      logic [7:0] echo_length;
      logic [7:0] expected_cmd_checksum;
   } cfg_type;

   typedef struct packed {
      logic       restart;
      logic [7:0] rx_byte;
   } item_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] data_byte;
      logic       last;
      status_type status;
   } result_type;

endpackage

`default_nettype wire

[rtl/core/rfc_in_stage.sv]
// ----------------------------------------------------------------------------
// Reply frame checker input register
// Holds one received byte until the parser consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module rfc_in_stage (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [7:0]        req_tdata,
   input  wire logic              req_tuser,
   input  wire logic              advance,
   output logic                   in_valid,
   output rfc_pkg::item_type      item
);
   import rfc_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;
   logic     accept;

   assign req_tready = !valid_ff || advance;
   assign accept     = req_tvalid && req_tready;
   assign in_valid   = valid_ff;
   assign item       = item_ff;

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (accept) begin
         item_ff.rx_byte <= req_tdata;
         item_ff.restart <= req_tuser;
      end
   end

endmodule

`default_nettype wire

[rtl/core/rfc_parser.sv]
// ----------------------------------------------------------------------------
// Reply frame checker parser
// Frame state and the per-byte decision for echo, header and payload bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module rfc_parser (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              advance,
   input  wire rfc_pkg::item_type item,
   input  wire rfc_pkg::cfg_type  cfg,
   output rfc_pkg::result_type    result
);
   import rfc_pkg::*;

   typedef enum logic [1:0] {PH_ECHO, PH_HDR, PH_PAY, PH_DONE} phase_type;

   phase_type   phase_ff, phase_in;
   logic [15:0] position_ff, position_in;
   logic [15:0] frame_length_ff, frame_length_in;
   logic [7:0]  got_cmd_ff, got_cmd_in;
   logic [15:0] got_reply_ff, got_reply_in;
   logic [15:0] running_ff, running_in;

   phase_type   cur_phase;
   logic [15:0] cur_pos, cur_flen, cur_grep, cur_run;
   logic [7:0]  cur_gcmd;
   logic [15:0] hdr_len, min_len, hdr_pos, hdr_flen, hdr_grep, run_new;
   logic [7:0]  hdr_gcmd;
   logic        hdr_go, sum_ok;
   logic [7:0]  b;

   assign b       = item.rx_byte;
   assign hdr_len = cfg.long_mode ? HDR_LONG : HDR_SHORT;
   assign min_len = hdr_len + PROMPT_LEN;

   always_comb begin
      // A restart clears the frame state before the byte is looked at.
      if (item.restart) begin
         cur_phase = PH_ECHO;
         cur_pos   = '0;
         cur_flen  = '0;
         cur_gcmd  = '0;
         cur_grep  = '0;
         cur_run   = '0;
      end else begin
         cur_phase = phase_ff;
         cur_pos   = position_ff;
         cur_flen  = frame_length_ff;
         cur_gcmd  = got_cmd_ff;
         cur_grep  = got_reply_ff;
         cur_run   = running_ff;
      end

      phase_in        = cur_phase;
      position_in     = cur_pos;
      frame_length_in = cur_flen;
      got_cmd_in      = cur_gcmd;
      got_reply_in    = cur_grep;
      running_in      = cur_run;
      result          = '0;
      result.status   = STATUS_OK;

      // The byte after the last echoed one is already the first header byte.
      hdr_go = 1'b0;
      if (cur_phase == PH_ECHO) begin
         if (cur_pos < {8'h00, cfg.echo_length}) begin
            position_in = cur_pos + 16'd1;
         end else begin
            hdr_go = 1'b1;
         end
      end
      hdr_pos = hdr_go ? 16'd0 : cur_pos;

      hdr_flen = cur_flen;
      hdr_gcmd = cur_gcmd;
      hdr_grep = cur_grep;
      if (cfg.long_mode) begin
         case (hdr_pos)
            16'd0:   hdr_flen = {b, 8'h00};
            16'd1:   hdr_flen = cur_flen | {8'h00, b};
            16'd2:   hdr_gcmd = b;
            16'd3:   hdr_grep = {b, 8'h00};
            default: hdr_grep = cur_grep | {8'h00, b};
         endcase
      end else begin
         case (hdr_pos)
            16'd0:   hdr_flen = {8'h00, b};
            16'd1:   hdr_gcmd = b;
            default: hdr_grep = {8'h00, b};
         endcase
      end

      run_new = cfg.long_mode ? (cur_run + {8'h00, b}) : {8'h00, cur_run[7:0] ^ b};
      sum_ok  = cfg.long_mode ? (run_new == cur_grep) : (run_new[7:0] == cur_grep[7:0]);

      if (hdr_go || (cur_phase == PH_HDR)) begin
         got_cmd_in   = hdr_gcmd;
         got_reply_in = hdr_grep;
         if (({1'b0, hdr_pos} + 17'd1) >= {1'b0, hdr_len}) begin
            position_in = '0;
            if (hdr_flen < min_len) begin
               frame_length_in = hdr_flen;
               phase_in        = PH_DONE;
               result.valid    = 1'b1;
               result.last     = 1'b1;
               result.status   = STATUS_TOO_SHORT;
            end else begin
               frame_length_in = hdr_flen - hdr_len;
               running_in      = '0;
               phase_in        = PH_PAY;
            end
         end else begin
            frame_length_in = hdr_flen;
            position_in     = hdr_pos + 16'd1;
            phase_in        = PH_HDR;
         end
      end else if (cur_phase == PH_PAY) begin
         running_in = run_new;
         if (({1'b0, cur_pos} + 17'd1) >= {1'b0, cur_flen}) begin
            phase_in     = PH_DONE;
            position_in  = '0;
            result.valid = 1'b1;
            result.last  = 1'b1;
            if (b != TERM_CHAR) begin
               result.status = STATUS_BAD_TERM;
            end else if (cur_gcmd != cfg.expected_cmd_checksum) begin
               result.status = STATUS_CMD_SUM;
            end else if (!sum_ok) begin
               result.status = STATUS_REPLY_SUM;
            end else begin
               result.status = STATUS_OK;
            end
         end else begin
            position_in = cur_pos + 16'd1;
            // Bytes of the closing prompt are counted but not forwarded.
            if (({1'b0, cur_pos} + {1'b0, PROMPT_LEN}) < {1'b0, cur_flen}) begin
               result.valid     = 1'b1;
               result.data_byte = b;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_ECHO;
         position_ff     <= '0;
         frame_length_ff <= '0;
         got_cmd_ff      <= '0;
         got_reply_ff    <= '0;
         running_ff      <= '0;
      end else if (advance) begin
         phase_ff        <= phase_in;
         position_ff     <= position_in;
         frame_length_ff <= frame_length_in;
         got_cmd_ff      <= got_cmd_in;
         got_reply_ff    <= got_reply_in;
         running_ff      <= running_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/rfc_out_stage.sv]
// ----------------------------------------------------------------------------
// Reply frame checker result register
// Holds one forwarded byte or end item until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module rfc_out_stage (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                advance,
   input  wire rfc_pkg::result_type result,
   output logic                     out_valid,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic [7:0]               rsp_tdata,
   output logic                     rsp_tlast,
   output logic [2:0]               rsp_tuser
);
   import rfc_pkg::*;

   logic       valid_ff, valid_in;
   logic       load;
   logic [7:0] data_ff;
   logic       last_ff;
   logic [2:0] status_ff;

   assign load = advance && result.valid;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         data_ff   <= result.data_byte;
         last_ff   <= result.last;
         status_ff <= result.status;
      end
   end

   assign out_valid  = valid_ff;
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = status_ff;

endmodule

`default_nettype wire

[rtl/core/reply_frame_checker.sv]
// ----------------------------------------------------------------------------
// Reply frame checker
// Checks reply frames from a recorder link byte by byte, forwards the payload
// without its closing prompt and ends each frame with one status item.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Payload                         Handshake
//   req_      in         tdata[7:0] rx_byte,             tvalid/tready
//                        tuser restart
//   rsp_      out        tdata[7:0] data_byte,           tvalid/tready
//                        tlast last, tuser[2:0] status
//   csr_      in         index[1:0], wdata[7:0]          we, no wait
//
// Each request waits in the input register and is decided in the cycle it moves
// on, when any result is loaded into the result register; one request is taken
// every cycle while the result side keeps up.
// The per-byte frame state update (counters plus the running XOR or byte sum)
// is the single combinational step that sets the cycle time.
// When the result register is full and not taken, the input register holds
// its request and further requests wait; nothing is dropped.
// Reset is synchronous and active high; it clears the frame state and the
// configuration registers, and the block is ready in the next cycle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "reply_frame_checker_defines.svh"

module reply_frame_checker (
   input  wire logic       clock,
   input  wire logic       reset,
   // Request channel.
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] rx_byte
   input  wire logic       req_tuser,   // [0] restart
   // Result channel.
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [7:0] data_byte
   output logic            rsp_tlast,
   output logic [2:0]      rsp_tuser,   // [2:0] status
   // Configuration writes.
   input  wire logic       csr_we,
   input  wire logic [1:0] csr_index,
   input  wire logic [7:0] csr_wdata
);
   import rfc_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   item_type   item;
   result_type result;
   logic       in_valid;
   logic       out_valid;
   logic       advance;

   // A request leaves the input register whenever the result register is
   // free or is being emptied in the same cycle.
   assign advance = in_valid && (!out_valid || rsp_tready);

   // Configuration registers; a write to an unused index is ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_LONG_MODE:   cfg_in.long_mode             = csr_wdata[0];
            CSR_ECHO_LENGTH: cfg_in.echo_length           = csr_wdata;
            CSR_EXP_CMD_SUM: cfg_in.expected_cmd_checksum = csr_wdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rfc_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .advance    (advance),
      .in_valid   (in_valid),
      .item       (item)
   );

   rfc_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item),
      .cfg     (cfg_ff),
      .result  (result)
   );

   rfc_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .result     (result),
      .out_valid  (out_valid),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // The end item never carries payload data.
   `RFC_ASSERT_IMPL(a_end_item_zero_data, rsp_tvalid && rsp_tlast, rsp_tdata == 8'h00, "end item with nonzero data")
   // Forwarded payload bytes always report a clean status.
   `RFC_ASSERT_IMPL(a_data_item_ok, rsp_tvalid && !rsp_tlast, rsp_tuser == STATUS_OK, "data item with nonzero status")
   // Only defined status codes reach the port.
   `RFC_ASSERT_IMPL(a_status_defined, rsp_tvalid, rsp_tuser <= STATUS_TOO_SHORT, "undefined status code")
   // A request that could not move on is still held in the next cycle.
   `RFC_ASSERT_NEXT(a_request_held, in_valid && !advance, in_valid, "stalled request lost")

endmodule

`default_nettype wire
